### rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the proximity blink scheduler.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### rtl/pbs_pkg.sv
// Shared widths, reset values and codes for the proximity blink scheduler.
// No dependencies; imported by pbs_period_unit and proximity_blink_scheduler.
`default_nettype none

package pbs_pkg;

    localparam int unsigned DIST_W_DEFAULT = 10;
    localparam int unsigned ALARM_W        = 10;
    localparam int unsigned PERIOD_W       = 16;
    localparam int unsigned CFG_ADDR_W     = 2;
    localparam int unsigned CFG_DATA_W     = 16;

    localparam logic [ALARM_W-1:0]  ALARM_RESET = ALARM_W'(30);
    localparam logic [PERIOD_W-1:0] SAFE_RESET  = PERIOD_W'(1000);
    localparam logic [PERIOD_W-1:0] MIN_RESET   = PERIOD_W'(80);
    localparam logic [PERIOD_W-1:0] PING_RESET  = PERIOD_W'(120);

    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_READING = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ALARM = 2'd0,
        REG_SAFE  = 2'd1,
        REG_MIN   = 2'd2,
        REG_PING  = 2'd3
    } pbs_reg_idx_t;

endpackage

`default_nettype wire

### rtl/pbs_period_unit.sv
// Serial blink period unit: min + d * span / alarm by shift-add then restoring division.
// Depends on pbs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pbs_period_unit #(
    parameter int unsigned DIST_W = pbs_pkg::DIST_W_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [DIST_W-1:0]             dist_in,
    input  logic [pbs_pkg::PERIOD_W-1:0]  span,
    input  logic [pbs_pkg::PERIOD_W-1:0]  min_period,
    input  logic [pbs_pkg::ALARM_W-1:0]   alarm,
    output logic                          done,
    output logic [pbs_pkg::PERIOD_W-1:0]  period
);
    import pbs_pkg::*;

    localparam int unsigned PROD_W    = DIST_W + PERIOD_W;
    localparam int unsigned STEPS_MAX = (DIST_W > PERIOD_W) ? DIST_W : PERIOD_W;
    localparam int unsigned CNT_W     = $clog2(STEPS_MAX);

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV
    } ustate_t;

    ustate_t              state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIST_W-1:0]    d_sh_reg, d_sh_next;
    logic [PERIOD_W-1:0]  span_reg, span_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [ALARM_W-1:0]   rem_reg, rem_next;
    logic [PERIOD_W-1:0]  q_reg, q_next;
    logic                 done_reg, done_next;

    logic [PROD_W-1:0]    addend;
    logic [PROD_W-1:0]    acc_sum;
    logic [ALARM_W:0]     trial;
    logic [ALARM_W:0]     trial_sub;
    logic                 fits;

    // One multiplier bit per cycle, MSB first.
    assign addend  = d_sh_reg[DIST_W-1] ? PROD_W'(span_reg) : '0;
    assign acc_sum = {acc_reg[PROD_W-2:0], 1'b0} + addend;

    // One quotient bit per cycle.
    assign trial     = {rem_reg, q_reg[PERIOD_W-1]};
    assign fits      = (trial >= {1'b0, alarm});
    assign trial_sub = trial - {1'b0, alarm};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        d_sh_next  = d_sh_reg;
        span_next  = span_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            U_IDLE: begin
                if (start) begin
                    d_sh_next  = dist_in;
                    span_next  = span;
                    acc_next   = '0;
                    cnt_next   = CNT_W'(DIST_W - 1);
                    state_next = U_MUL;
                end
            end
            U_MUL: begin
                acc_next  = acc_sum;
                d_sh_next = {d_sh_reg[DIST_W-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    // Upper part of the product is below alarm, so it fits the remainder.
                    rem_next   = ALARM_W'(acc_sum[PROD_W-1:PERIOD_W]);
                    q_next     = acc_sum[PERIOD_W-1:0];
                    cnt_next   = CNT_W'(PERIOD_W - 1);
                    state_next = U_DIV;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            U_DIV: begin
                rem_next = fits ? trial_sub[ALARM_W-1:0] : trial[ALARM_W-1:0];
                q_next   = {q_reg[PERIOD_W-2:0], fits};
                if (cnt_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
        d_sh_reg <= d_sh_next;
        span_reg <= span_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign done   = done_reg;
    assign period = min_period + q_reg;

    `ASSERT_CLK(a_start_idle, start |-> (state_reg == U_IDLE), "start while unit busy")
    `ASSERT_CLK(a_done_pulse, done_reg |=> !done_reg, "done longer than one cycle")
    `ASSERT_CLK(a_rem_below, (state_reg == U_DIV) |-> (rem_reg < alarm),
                "division remainder not below divisor")

endmodule

`default_nettype wire

### rtl/proximity_blink_scheduler.sv
// Proximity blink scheduler: tick-driven ping schedule and distance-proportional LED blink.
// Ticks, zero readings and readings at or beyond the alarm distance: result in the next cycle.
// Readings inside the zone: the result waits for the serial multiply/divide unit.
// Throughput: one word per cycle for ticks if m_ready holds; next word waits for a zone reading.
// Reset (aresetn low, synchronous) restores register defaults and clears all schedule state.
// Depends on pbs_pkg, pbs_period_unit and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module proximity_blink_scheduler #(
    parameter int unsigned DISTANCE_BITS = pbs_pkg::DIST_W_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [pbs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pbs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input words
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [DISTANCE_BITS-1:0]        s_distance_cm,
    // result words
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_led_on,
    output logic                            m_ping_request,
    output logic                            m_in_zone,
    output logic                            m_have_reading
);
    import pbs_pkg::*;

    localparam int unsigned CMP_W = (DISTANCE_BITS > ALARM_W) ? DISTANCE_BITS : ALARM_W;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    // configuration
    logic [ALARM_W-1:0]       alarm_reg, alarm_next;
    logic [PERIOD_W-1:0]      safe_reg, safe_next;
    logic [PERIOD_W-1:0]      min_reg, min_next;
    logic [PERIOD_W-1:0]      ping_per_reg, ping_per_next;

    // schedule state
    state_t                   state_reg, state_next;
    logic                     seen_reg, seen_next;
    logic [DISTANCE_BITS-1:0] dist_reg, dist_next;
    logic [PERIOD_W-1:0]      blink_per_reg, blink_per_next;
    logic [PERIOD_W-1:0]      ping_wait_reg, ping_wait_next;
    logic [PERIOD_W-1:0]      blink_wait_reg, blink_wait_next;
    logic                     led_reg, led_next;

    // output word
    logic                     m_valid_reg, m_valid_next;
    logic                     o_led_reg, o_led_next;
    logic                     o_ping_reg, o_ping_next;
    logic                     o_zone_reg, o_zone_next;
    logic                     o_have_reg, o_have_next;

    logic                     accept;
    logic                     d_nonzero;
    logic                     d_below;
    logic                     stored_below;
    logic [PERIOD_W-1:0]      span;
    logic                     u_start;
    logic                     u_done;
    logic [PERIOD_W-1:0]      u_period;

    // Take a new word only when idle and the output slot is empty or empties this cycle.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign d_nonzero    = (s_distance_cm != '0);
    assign d_below      = (CMP_W'(s_distance_cm) < CMP_W'(alarm_reg));
    assign stored_below = (CMP_W'(dist_reg) < CMP_W'(alarm_reg));

    // Span clamps to zero when the safe period is below the minimum.
    assign span = (safe_reg >= min_reg) ? (safe_reg - min_reg) : '0;

    // A zero alarm distance never reaches the divider: nothing is below it.
    assign u_start = accept && (s_action == ACT_READING) && d_nonzero && d_below;

    pbs_period_unit #(
        .DIST_W (DISTANCE_BITS)
    ) u_period_unit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (u_start),
        .dist_in    (s_distance_cm),
        .span       (span),
        .min_period (min_reg),
        .alarm      (alarm_reg),
        .done       (u_done),
        .period     (u_period)
    );

    always_comb begin
        alarm_next      = alarm_reg;
        safe_next       = safe_reg;
        min_next        = min_reg;
        ping_per_next   = ping_per_reg;
        state_next      = state_reg;
        seen_next       = seen_reg;
        dist_next       = dist_reg;
        blink_per_next  = blink_per_reg;
        ping_wait_next  = ping_wait_reg;
        blink_wait_next = blink_wait_reg;
        led_next        = led_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        o_led_next      = o_led_reg;
        o_ping_next     = o_ping_reg;
        o_zone_next     = o_zone_reg;
        o_have_next     = o_have_reg;

        if (cfg_wr_en) begin
            unique case (pbs_reg_idx_t'(cfg_addr))
                REG_ALARM: alarm_next    = cfg_wdata[ALARM_W-1:0];
                REG_SAFE:  safe_next     = cfg_wdata[PERIOD_W-1:0];
                REG_MIN:   min_next      = cfg_wdata[PERIOD_W-1:0];
                REG_PING:  ping_per_next = cfg_wdata[PERIOD_W-1:0];
                default:   ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_TICK) begin
                        // Ping countdown: request on zero, then reload.
                        o_ping_next = (ping_wait_reg == '0);
                        if (ping_wait_reg == '0) begin
                            ping_wait_next = (ping_per_reg != '0) ? ping_per_reg - 1'b1 : '0;
                        end else begin
                            ping_wait_next = ping_wait_reg - 1'b1;
                        end
                        // Blink countdown runs only once a reading exists.
                        if (seen_reg) begin
                            if (blink_wait_reg == '0) begin
                                led_next        = !led_reg;
                                blink_wait_next = (blink_per_reg != '0) ?
                                                  blink_per_reg - 1'b1 : '0;
                            end else begin
                                blink_wait_next = blink_wait_reg - 1'b1;
                            end
                        end
                        o_led_next   = seen_reg && led_next;
                        o_zone_next  = seen_reg && stored_below;
                        o_have_next  = seen_reg;
                        m_valid_next = 1'b1;
                    end else if (!d_nonzero) begin
                        // No echo: report state, change nothing.
                        o_led_next   = seen_reg && led_reg;
                        o_ping_next  = 1'b0;
                        o_zone_next  = seen_reg && stored_below;
                        o_have_next  = seen_reg;
                        m_valid_next = 1'b1;
                    end else if (!d_below) begin
                        // At or beyond the boundary: safe period, no division.
                        seen_next      = 1'b1;
                        dist_next      = s_distance_cm;
                        blink_per_next = safe_reg;
                        o_led_next     = led_reg;
                        o_ping_next    = 1'b0;
                        o_zone_next    = 1'b0;
                        o_have_next    = 1'b1;
                        m_valid_next   = 1'b1;
                    end else begin
                        // Inside the zone: hold the distance and wait for the unit.
                        dist_next  = s_distance_cm;
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                if (u_done) begin
                    seen_next      = 1'b1;
                    blink_per_next = u_period;
                    o_led_next     = led_reg;
                    o_ping_next    = 1'b0;
                    o_zone_next    = 1'b1;
                    o_have_next    = 1'b1;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_reg      <= ALARM_RESET;
            safe_reg       <= SAFE_RESET;
            min_reg        <= MIN_RESET;
            ping_per_reg   <= PING_RESET;
            state_reg      <= ST_IDLE;
            seen_reg       <= 1'b0;
            dist_reg       <= '0;
            blink_per_reg  <= '0;
            ping_wait_reg  <= '0;
            blink_wait_reg <= '0;
            led_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            alarm_reg      <= alarm_next;
            safe_reg       <= safe_next;
            min_reg        <= min_next;
            ping_per_reg   <= ping_per_next;
            state_reg      <= state_next;
            seen_reg       <= seen_next;
            dist_reg       <= dist_next;
            blink_per_reg  <= blink_per_next;
            ping_wait_reg  <= ping_wait_next;
            blink_wait_reg <= blink_wait_next;
            led_reg        <= led_next;
            m_valid_reg    <= m_valid_next;
        end
        o_led_reg  <= o_led_next;
        o_ping_reg <= o_ping_next;
        o_zone_reg <= o_zone_next;
        o_have_reg <= o_have_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_led_on       = o_led_reg;
    assign m_ping_request = o_ping_reg;
    assign m_in_zone      = o_zone_reg;
    assign m_have_reading = o_have_reg;

    `ASSERT_CLK(a_done_in_calc, u_done |-> (state_reg == ST_CALC),
                "period unit finished outside a zone reading")
    `ASSERT_CLK(a_tick_result, (accept && (s_action == ACT_TICK)) |=> m_valid,
                "tick word gave no result on the next cycle")
    `ASSERT_CLK(a_led_needs_data, m_valid |-> (!m_led_on || m_have_reading),
                "LED lit before any reading")

endmodule

`default_nettype wire
